FILE: rtl/core/spa_pkg.sv
package spa_pkg;

   // Fixed-point format of angles and trig values: signed Q29
   localparam int QB = 29;
   localparam int STEPS = 28;
   localparam int ATAN_STEPS = 12;
   localparam int ROOT_STEPS = 30;
   localparam int DIV_STEPS = 30;

   localparam logic signed [31:0] ONE_Q = 32'sd536870912;
   localparam logic signed [31:0] PI_Q = 32'sd1686629713;
   localparam logic signed [31:0] HALF_PI_Q = 32'sd843314857;
   localparam logic signed [34:0] TWO_PI_Q = 35'sd3373259426;
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd326016437;
   localparam logic signed [31:0] DECL_AMP = 32'sd219730371;
   localparam logic signed [31:0] DEG_PER_RAD_Q24 = 32'sd961263669;
   localparam logic [14:0] LAT_RESET = 15'd8870;

   // Declination phase: 2*pi*n2/730 = n2*PH_Q0 + (n2*PH_R0 + 365)/730
   localparam logic [22:0] PH_Q0 = 23'd4620903;
   localparam logic [8:0] PH_R0 = 9'd236;
   localparam logic [9:0] PH_DIV = 10'd730;
   localparam logic [9:0] PH_BIAS = 10'd365;
   localparam logic [18:0] PH_RECIP = 19'd367719;

   // Hour angle: pi*|d|/720 = |d|*HR_Q0 + (|d|*HR_R0 + 360)/720
   localparam logic [21:0] HR_Q0 = 22'd2342541;
   localparam logic [8:0] HR_R0 = 9'd193;
   localparam logic [9:0] HR_DIV = 10'd720;
   localparam logic [9:0] HR_BIAS = 10'd360;
   localparam logic [18:0] HR_RECIP = 19'd372827;
   localparam int RECIP_SHIFT = 28;

   localparam logic signed [31:0] ATAN_TAB [ATAN_STEPS] = '{
      32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762580,
      32'sd33510843, 32'sd16771757, 32'sd8387925, 32'sd4194219,
      32'sd2097141, 32'sd1048575, 32'sd524288, 32'sd262144
   };

   // Rotation angle of CORDIC step idx
   function automatic logic signed [31:0] step_angle(input int idx);
      logic signed [31:0] a;
      if (idx < ATAN_STEPS) begin
         a = ATAN_TAB[idx[3:0]];
      end else begin
         a = 32'sd1 <<< (QB - idx);
      end
      return a;
   endfunction

   // Q29 product, rounded half up
   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + (64'sd1 <<< (QB - 1));
      return 32'(p >>> QB);
   endfunction

endpackage

FILE: rtl/core/solar_position_angles.sv
// Sun elevation and direction angle for a calendar time stamp (month, day, hour,
// minute) at the latitude held in csr_write_data's register (radians, unsigned Q1.14).
// Fully pipelined: one item is taken every clock while the output is not stalled;
// items pass through the day/hour arithmetic stages, two 29-stage sine/cosine
// CORDICs, two 61-stage arcsine units (square root plus vectoring CORDIC) and a
// 31-stage divider, with product and degree scaling stages between them.
// A stalled output freezes the whole pipeline. Results are degrees with
// ANGLE_FRAC_BITS fraction bits, saturated to 16 bits; direction is 0 and
// rsp_direction_undefined is set when the elevation cosine is zero. Write the
// latitude only while no item is in flight.
module solar_position_angles #(
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day,
   input  logic [4:0]         req_hour,
   input  logic [5:0]         req_minute,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_elevation_deg,
   output logic signed [15:0] rsp_direction_deg,
   output logic               rsp_direction_undefined,
   input  logic               csr_write_enable,
   input  logic [14:0]        csr_write_data
);
   import spa_pkg::*;

   localparam int DEG_SHIFT = 53 - ANGLE_FRAC_BITS;

   logic adv;
   logic [14:0] lat_ff;

   // Stage A: day-of-year and minute-from-noon
   logic [10:0] n2raw_in, n2_in;
   logic [10:0] tmraw_in, tm_in;
   logic signed [11:0] d_in;
   logic        a_valid_ff;
   logic [9:0]  a_n2_ff;
   logic [9:0]  a_ad_ff;
   logic        a_neg_ff;

   // Stage B: base products and remainders
   logic        b_valid_ff;
   logic [17:0] b_xp_ff, b_xh_ff;
   logic [32:0] b_basep_ff;
   logic [30:0] b_baseh_ff;
   logic        b_neg_ff;

   // Stage C: reciprocal estimates
   logic        c_valid_ff;
   logic [8:0]  c_ep_ff, c_eh_ff;
   logic [17:0] c_xp_ff, c_xh_ff;
   logic [32:0] c_basep_ff;
   logic [30:0] c_baseh_ff;
   logic        c_neg_ff;

   // Stage D: corrected quotients
   logic [18:0] rp_in, rh_in;
   logic        d_valid_ff;
   logic [8:0]  d_qp_ff, d_qh_ff;
   logic [32:0] d_basep_ff;
   logic [30:0] d_baseh_ff;
   logic        d_neg_ff;

   // Stage E: phase and hour angle
   logic signed [34:0] phase_in;
   logic signed [31:0] mag_in;
   logic        e_valid_ff;
   logic signed [31:0] e_phase_ff, e_tau_ff;

   logic        u1_valid;
   logic signed [31:0] u1_sin, u1_tau;
   logic signed [31:0] u2_sin, u2_cos;

   // Stage F: declination
   logic        f_valid_ff;
   logic signed [31:0] f_dec_ff, f_tau_ff, f_sl_ff, f_cl_ff;

   logic        u3_valid;
   logic signed [31:0] u3_sin, u3_cos;
   logic [63:0] u3_side;
   logic signed [31:0] u4_sin, u4_cos;

   // Stages G, H, I: asin argument
   logic        g_valid_ff;
   logic signed [31:0] g_p1_ff, g_p2_ff, g_p3_ff, g_ct_ff;
   logic        h_valid_ff;
   logic signed [31:0] h_p1_ff, h_p4_ff, h_p3_ff;
   logic signed [32:0] sum_in;
   logic signed [31:0] arg_in;
   logic        i_valid_ff;
   logic signed [31:0] i_arg_ff, i_p3_ff;

   logic        u5_valid;
   logic signed [31:0] u5_elev;
   logic [29:0] u5_cos;
   logic [31:0] u5_side;

   logic        dv_valid;
   logic signed [31:0] dv_quot;
   logic        dv_zero;
   logic [31:0] dv_side;

   logic        u6_valid;
   logic signed [31:0] u6_dir;
   logic [32:0] u6_side;

   // Stage J: scale to degrees
   logic        j_valid_ff;
   logic signed [63:0] j_pe_ff, j_pd_ff;
   logic        j_flag_ff;

   logic        rsp_valid_ff;
   logic signed [15:0] rsp_elev_ff, rsp_dir_ff;
   logic        rsp_flag_ff;

   function automatic logic signed [15:0] to_deg(input logic signed [63:0] p);
      logic signed [63:0] v;
      v = (p + (64'sd1 <<< (DEG_SHIFT - 1))) >>> DEG_SHIFT;
      if (v > 64'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -64'sd32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   // Freeze every stage while a finished item waits
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Latitude register
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= LAT_RESET;
      end else if (csr_write_enable) begin
         lat_ff <= csr_write_data;
      end
   end

   // Wrap day index mod 730 and minute of day mod 1440
   always_comb begin
      n2raw_in = 11'd507 + 11'(req_month) * 11'd61 + {5'd0, req_day, 1'b0};
      if (n2raw_in >= 11'd1460) begin
         n2_in = n2raw_in - 11'd1460;
      end else if (n2raw_in >= 11'd730) begin
         n2_in = n2raw_in - 11'd730;
      end else begin
         n2_in = n2raw_in;
      end
      tmraw_in = 11'(req_hour) * 11'd60 + 11'(req_minute);
      tm_in = (tmraw_in >= 11'd1440) ? tmraw_in - 11'd1440 : tmraw_in;
      d_in = $signed({1'b0, tm_in}) - 12'sd720;
   end

   always_comb begin
      rp_in = 19'(c_xp_ff) - 19'(c_ep_ff) * 19'(PH_DIV);
      rh_in = 19'(c_xh_ff) - 19'(c_eh_ff) * 19'(HR_DIV);
      phase_in = $signed({2'b0, d_basep_ff}) + 35'sd0 + $signed({26'd0, d_qp_ff});
      if (phase_in > 35'(PI_Q)) begin
         phase_in = phase_in - TWO_PI_Q;
      end
      mag_in = $signed({1'b0, d_baseh_ff}) + $signed({23'd0, d_qh_ff});
   end

   // Front stages A to E
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
      if (adv) begin
         a_n2_ff <= n2_in[9:0];
         a_ad_ff <= d_in[11] ? 10'(-d_in) : 10'(d_in);
         a_neg_ff <= d_in[11];

         b_xp_ff <= 18'(a_n2_ff) * 18'(PH_R0) + 18'(PH_BIAS);
         b_xh_ff <= 18'(a_ad_ff) * 18'(HR_R0) + 18'(HR_BIAS);
         b_basep_ff <= 33'(a_n2_ff) * 33'(PH_Q0);
         b_baseh_ff <= 31'(a_ad_ff) * 31'(HR_Q0);
         b_neg_ff <= a_neg_ff;

         c_ep_ff <= 9'((37'(b_xp_ff) * 37'(PH_RECIP)) >> RECIP_SHIFT);
         c_eh_ff <= 9'((37'(b_xh_ff) * 37'(HR_RECIP)) >> RECIP_SHIFT);
         c_xp_ff <= b_xp_ff;
         c_xh_ff <= b_xh_ff;
         c_basep_ff <= b_basep_ff;
         c_baseh_ff <= b_baseh_ff;
         c_neg_ff <= b_neg_ff;

         d_qp_ff <= c_ep_ff + 9'(rp_in >= 19'(PH_DIV));
         d_qh_ff <= c_eh_ff + 9'(rh_in >= 19'(HR_DIV));
         d_basep_ff <= c_basep_ff;
         d_baseh_ff <= c_baseh_ff;
         d_neg_ff <= c_neg_ff;

         e_phase_ff <= 32'(phase_in);
         e_tau_ff <= d_neg_ff ? -mag_in : mag_in;
      end
   end

   // Sine of the year phase, with latitude alongside
   spa_sincos #(.SIDE_W(32)) u_phase (
      .clock(clock), .reset(reset), .en(adv), .in_valid(e_valid_ff),
      .angle(e_phase_ff), .side_in(e_tau_ff),
      .out_valid(u1_valid), .sin_out(u1_sin), .cos_out(), .side_out(u1_tau)
   );

   spa_sincos #(.SIDE_W(1)) u_lat (
      .clock(clock), .reset(reset), .en(adv), .in_valid(e_valid_ff),
      .angle({2'b0, lat_ff, 15'd0}), .side_in(1'b0),
      .out_valid(), .sin_out(u2_sin), .cos_out(u2_cos), .side_out()
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= u1_valid;
      end
      if (adv) begin
         f_dec_ff <= mulq(u1_sin, DECL_AMP);
         f_tau_ff <= u1_tau;
         f_sl_ff <= u2_sin;
         f_cl_ff <= u2_cos;
      end
   end

   // Declination and hour angle trig
   spa_sincos #(.SIDE_W(64)) u_dec (
      .clock(clock), .reset(reset), .en(adv), .in_valid(f_valid_ff),
      .angle(f_dec_ff), .side_in({f_sl_ff, f_cl_ff}),
      .out_valid(u3_valid), .sin_out(u3_sin), .cos_out(u3_cos), .side_out(u3_side)
   );

   spa_sincos #(.SIDE_W(1)) u_tau (
      .clock(clock), .reset(reset), .en(adv), .in_valid(f_valid_ff),
      .angle(f_tau_ff), .side_in(1'b0),
      .out_valid(), .sin_out(u4_sin), .cos_out(u4_cos), .side_out()
   );

   assign sum_in = 33'(h_p1_ff) + 33'(h_p4_ff);
   always_comb begin
      if (sum_in > 33'(ONE_Q)) begin
         arg_in = ONE_Q;
      end else if (sum_in < -33'(ONE_Q)) begin
         arg_in = -ONE_Q;
      end else begin
         arg_in = 32'(sum_in);
      end
   end

   // Products for the elevation argument and the direction numerator
   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= u3_valid;
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
      end
      if (adv) begin
         g_p1_ff <= mulq(u3_side[63:32], u3_sin);
         g_p2_ff <= mulq(u3_side[31:0], u3_cos);
         g_p3_ff <= mulq(u3_cos, u4_sin);
         g_ct_ff <= u4_cos;
         h_p1_ff <= g_p1_ff;
         h_p4_ff <= mulq(g_p2_ff, g_ct_ff);
         h_p3_ff <= g_p3_ff;
         i_arg_ff <= arg_in;
         i_p3_ff <= h_p3_ff;
      end
   end

   spa_asin #(.SIDE_W(32)) u_elev (
      .clock(clock), .reset(reset), .en(adv), .in_valid(i_valid_ff),
      .value(i_arg_ff), .side_in(i_p3_ff),
      .out_valid(u5_valid), .angle_out(u5_elev), .cos_out(u5_cos), .side_out(u5_side)
   );

   spa_div #(.SIDE_W(32)) u_div (
      .clock(clock), .reset(reset), .en(adv), .in_valid(u5_valid),
      .num(u5_side), .den(u5_cos), .side_in(u5_elev),
      .out_valid(dv_valid), .quot_out(dv_quot), .zero_out(dv_zero), .side_out(dv_side)
   );

   spa_asin #(.SIDE_W(33)) u_dir (
      .clock(clock), .reset(reset), .en(adv), .in_valid(dv_valid),
      .value(dv_quot), .side_in({dv_zero, dv_side}),
      .out_valid(u6_valid), .angle_out(u6_dir), .cos_out(), .side_out(u6_side)
   );

   // Degree scaling, then round, saturate and hold for the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         j_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         j_valid_ff <= u6_valid;
         rsp_valid_ff <= j_valid_ff;
      end
      if (adv) begin
         j_pe_ff <= 64'($signed(u6_side[31:0])) * 64'(DEG_PER_RAD_Q24);
         j_pd_ff <= 64'(u6_dir) * 64'(DEG_PER_RAD_Q24);
         j_flag_ff <= u6_side[32];
         rsp_elev_ff <= to_deg(j_pe_ff);
         rsp_dir_ff <= j_flag_ff ? 16'sd0 : to_deg(j_pd_ff);
         rsp_flag_ff <= j_flag_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_elevation_deg = rsp_elev_ff;
   assign rsp_direction_deg = rsp_dir_ff;
   assign rsp_direction_undefined = rsp_flag_ff;

`ifndef SYNTHESIS
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction_undefined |-> rsp_direction_deg == 16'sd0)
      else $error("undefined direction item carries a nonzero angle");

   a_back_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output item is blocked");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(j_valid_ff))
      else $error("output item appeared without a pipeline item");
`endif

endmodule

FILE: rtl/core/spa_sincos.sv
module spa_sincos #(
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [31:0]   angle,
   input  logic [SIDE_W-1:0]    side_in,
   output logic                 out_valid,
   output logic signed [31:0]   sin_out,
   output logic signed [31:0]   cos_out,
   output logic [SIDE_W-1:0]    side_out
);
   import spa_pkg::*;

   logic signed [31:0] x_ff [0:STEPS];
   logic signed [31:0] y_ff [0:STEPS];
   logic signed [31:0] z_ff [0:STEPS];
   logic               neg_ff [0:STEPS];
   logic [SIDE_W-1:0]  side_ff [0:STEPS];
   logic               valid_ff [0:STEPS];

   logic signed [31:0] z_in;
   logic               neg_in;

   // Fold the angle into [-pi/2, pi/2]
   always_comb begin
      if (angle > HALF_PI_Q) begin
         z_in = angle - PI_Q;
         neg_in = 1'b1;
      end else if (angle < -HALF_PI_Q) begin
         z_in = angle + PI_Q;
         neg_in = 1'b1;
      end else begin
         z_in = angle;
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0] <= CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= z_in;
         neg_ff[0] <= neg_in;
         side_ff[0] <= side_in;
      end
   end

   // One rotation step per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [31:0] x_in, y_in, zs_in;
      always_comb begin
         if (!z_ff[i][31]) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            zs_in = z_ff[i] - step_angle(i);
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            zs_in = z_ff[i] + step_angle(i);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= zs_in;
            neg_ff[i+1] <= neg_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // Undo the fold
   assign sin_out = neg_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
   assign cos_out = neg_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
   assign side_out = side_ff[STEPS];
   assign out_valid = valid_ff[STEPS];

endmodule

FILE: rtl/core/spa_asin.sv
module spa_asin #(
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [31:0]   value,
   input  logic [SIDE_W-1:0]    side_in,
   output logic                 out_valid,
   output logic signed [31:0]   angle_out,
   output logic [29:0]          cos_out,
   output logic [SIDE_W-1:0]    side_out
);
   import spa_pkg::*;

   localparam logic [59:0] ONE_SQ = 60'd1 << (2 * QB);

   logic [59:0]        sq_ff;
   logic signed [31:0] sq_x_ff;
   logic [SIDE_W-1:0]  sq_side_ff;
   logic               sq_valid_ff;

   logic [59:0]        rv_ff [0:ROOT_STEPS];
   logic [59:0]        rr_ff [0:ROOT_STEPS];
   logic signed [31:0] rx_ff [0:ROOT_STEPS];
   logic [SIDE_W-1:0]  rside_ff [0:ROOT_STEPS];
   logic               rvalid_ff [0:ROOT_STEPS];

   logic signed [31:0] vx_ff [0:STEPS];
   logic signed [31:0] vy_ff [0:STEPS];
   logic signed [31:0] vz_ff [0:STEPS];
   logic [29:0]        vc_ff [0:STEPS];
   logic [SIDE_W-1:0]  vside_ff [0:STEPS];
   logic               vvalid_ff [0:STEPS];

   logic [29:0] ax_in;

   assign ax_in = value[31] ? 30'(-value) : 30'(value);

   // Square, then 1 - x^2
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         rvalid_ff[0] <= 1'b0;
      end else if (en) begin
         sq_valid_ff <= in_valid;
         rvalid_ff[0] <= sq_valid_ff;
      end
      if (en) begin
         sq_ff <= 60'(ax_in) * 60'(ax_in);
         sq_x_ff <= value;
         sq_side_ff <= side_in;
         rv_ff[0] <= ONE_SQ - sq_ff;
         rr_ff[0] <= '0;
         rx_ff[0] <= sq_x_ff;
         rside_ff[0] <= sq_side_ff;
      end
   end

   // Square root, one result bit per stage
   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_root
      localparam logic [59:0] BIT = 60'd1 << (2 * (ROOT_STEPS - 1 - s));
      logic [59:0] t_in, v_in, r_in;
      always_comb begin
         t_in = rr_ff[s] + BIT;
         if (rv_ff[s] >= t_in) begin
            v_in = rv_ff[s] - t_in;
            r_in = (rr_ff[s] >> 1) + BIT;
         end else begin
            v_in = rv_ff[s];
            r_in = rr_ff[s] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rvalid_ff[s+1] <= 1'b0;
         end else if (en) begin
            rvalid_ff[s+1] <= rvalid_ff[s];
         end
         if (en) begin
            rv_ff[s+1] <= v_in;
            rr_ff[s+1] <= r_in;
            rx_ff[s+1] <= rx_ff[s];
            rside_ff[s+1] <= rside_ff[s];
         end
      end
   end

   // Load the vectoring unit with (sqrt(1-x^2), x)
   always_ff @(posedge clock) begin
      if (reset) begin
         vvalid_ff[0] <= 1'b0;
      end else if (en) begin
         vvalid_ff[0] <= rvalid_ff[ROOT_STEPS];
      end
      if (en) begin
         vx_ff[0] <= 32'(rr_ff[ROOT_STEPS][29:0]);
         vy_ff[0] <= rx_ff[ROOT_STEPS];
         vz_ff[0] <= '0;
         vc_ff[0] <= rr_ff[ROOT_STEPS][29:0];
         vside_ff[0] <= rside_ff[ROOT_STEPS];
      end
   end

   // One vectoring step per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_vec
      logic signed [31:0] x_in, y_in, z_in;
      always_comb begin
         if (!vy_ff[i][31]) begin
            x_in = vx_ff[i] + (vy_ff[i] >>> i);
            y_in = vy_ff[i] - (vx_ff[i] >>> i);
            z_in = vz_ff[i] + step_angle(i);
         end else begin
            x_in = vx_ff[i] - (vy_ff[i] >>> i);
            y_in = vy_ff[i] + (vx_ff[i] >>> i);
            z_in = vz_ff[i] - step_angle(i);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vvalid_ff[i+1] <= 1'b0;
         end else if (en) begin
            vvalid_ff[i+1] <= vvalid_ff[i];
         end
         if (en) begin
            vx_ff[i+1] <= x_in;
            vy_ff[i+1] <= y_in;
            vz_ff[i+1] <= z_in;
            vc_ff[i+1] <= vc_ff[i];
            vside_ff[i+1] <= vside_ff[i];
         end
      end
   end

   assign angle_out = vz_ff[STEPS];
   assign cos_out = vc_ff[STEPS];
   assign side_out = vside_ff[STEPS];
   assign out_valid = vvalid_ff[STEPS];

endmodule

FILE: rtl/core/spa_div.sv
module spa_div #(
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [31:0]   num,
   input  logic [29:0]          den,
   input  logic [SIDE_W-1:0]    side_in,
   output logic                 out_valid,
   output logic signed [31:0]   quot_out,
   output logic                 zero_out,
   output logic [SIDE_W-1:0]    side_out
);
   import spa_pkg::*;

   logic [61:0]        rem_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff [0:DIV_STEPS];
   logic [29:0]        den_ff [0:DIV_STEPS];
   logic               sign_ff [0:DIV_STEPS];
   logic               zero_ff [0:DIV_STEPS];
   logic               ovf_ff [0:DIV_STEPS];
   logic [SIDE_W-1:0]  side_ff [0:DIV_STEPS];
   logic               valid_ff [0:DIV_STEPS];

   logic [61:0] num_in;
   logic [30:0] mag_in;
   logic [31:0] sat_mag;

   // Scale |num| by one in Q29; flag a quotient that cannot fit
   assign mag_in = num[31] ? 31'(-num) : 31'(num);
   assign num_in = 62'(mag_in) << QB;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0] <= num_in;
         q_ff[0] <= '0;
         den_ff[0] <= den;
         sign_ff[0] <= num[31];
         zero_ff[0] <= (den == '0);
         ovf_ff[0] <= num_in >= (62'(den) << DIV_STEPS);
         side_ff[0] <= side_in;
      end
   end

   // Restoring division, one quotient bit per stage
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      logic [61:0] d_in, rem_in;
      logic        bit_in;
      always_comb begin
         d_in = 62'(den_ff[s]) << (DIV_STEPS - 1 - s);
         bit_in = rem_ff[s] >= d_in;
         rem_in = bit_in ? rem_ff[s] - d_in : rem_ff[s];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (en) begin
            rem_ff[s+1] <= rem_in;
            q_ff[s+1] <= {q_ff[s][DIV_STEPS-2:0], bit_in};
            den_ff[s+1] <= den_ff[s];
            sign_ff[s+1] <= sign_ff[s];
            zero_ff[s+1] <= zero_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   // Clamp to one, then apply the sign
   always_comb begin
      if (ovf_ff[DIV_STEPS] || (32'(q_ff[DIV_STEPS]) > ONE_Q)) begin
         sat_mag = ONE_Q;
      end else begin
         sat_mag = 32'(q_ff[DIV_STEPS]);
      end
   end

   assign quot_out = sign_ff[DIV_STEPS] ? -$signed(sat_mag) : $signed(sat_mag);
   assign zero_out = zero_ff[DIV_STEPS];
   assign side_out = side_ff[DIV_STEPS];
   assign out_valid = valid_ff[DIV_STEPS];

endmodule
